// ===== rtl/aes256_cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-256 CBC package
// Word types, register indexes, state codes and the round functions that
// the cipher's shared round unit and key schedule are built from.
// ----------------------------------------------------------------------------
package aes256_cbc_pkg;

  // Input word: one 128-bit block and the chain restart flag.
  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
  } in_word_t;

  // Output word: one processed block.
  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IV_HIGH = 3'd4;
  localparam logic [2:0] REG_IV_LOW = 3'd5;
  localparam logic [2:0] REG_DIRECTION = 3'd6;

  localparam int NUM_ROUNDS = 14;
  localparam int NUM_RKEYS = NUM_ROUNDS + 1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_START,
    ST_ROUND,
    ST_FINISH
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte substitution over a whole state; byte 0 sits in the top bits.
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return o;
  endfunction

  // Row rotation; byte 4c+r holds row r of column c.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          o[127-8*(((c+r)%4)*4+r) -: 8] = s[127-8*(c*4+r) -: 8];
        end else begin
          o[127-8*(c*4+r) -: 8] = s[127-8*(((c+r)%4)*4+r) -: 8];
        end
      end
    end
    return o;
  endfunction

  // Forward or inverse column mixing.
  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
      z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
      if (inv) begin
        // 9 = z^a, 11 = z^x^a, 13 = z^y^a, 14 = z^y^x
        o[127-32*c -: 8] = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
        o[119-32*c -: 8] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
        o[111-32*c -: 8] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
        o[103-32*c -: 8] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
      end else begin
        o[127-32*c -: 8] = x0 ^ (x1^a1) ^ a2 ^ a3;
        o[119-32*c -: 8] = a0 ^ x1 ^ (x2^a2) ^ a3;
        o[111-32*c -: 8] = a0 ^ a1 ^ x2 ^ (x3^a3);
        o[103-32*c -: 8] = (x0^a0) ^ a1 ^ a2 ^ x3;
      end
    end
    return o;
  endfunction

  // Substitute each byte of one 32-bit schedule word.
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Next 128-bit round key from the two before it.
  function automatic logic [127:0] next_round_key(input logic [127:0] kp2,
                                                  input logic [127:0] kp1,
                                                  input logic [7:0]   rcon,
                                                  input logic         rot);
    logic [31:0] t, w0, w1, w2, w3;
    if (rot) begin
      t = sub_word({kp1[23:0], kp1[31:24]}) ^ {rcon, 24'h0};
    end else begin
      t = sub_word(kp1[31:0]);
    end
    w0 = kp2[127:96] ^ t;
    w1 = kp2[95:64] ^ w0;
    w2 = kp2[63:32] ^ w1;
    w3 = kp2[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== rtl/aes256_cbc_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-256 CBC cipher
// Iterative AES-256 encrypt/decrypt core with CBC chaining and an on-demand
// key schedule.
// ----------------------------------------------------------------------------
// One block goes through a single shared round unit, one round per cycle.
// A word is accepted in the idle cycle. It then goes through the initial key
// addition, 14 rounds and the handoff of the result to the output register.
// The first block after reset or after any key word write first runs the key
// schedule, one 128-bit round key per cycle. The input is stalled while a
// word is in progress. A finished result waits in the output register while
// the next word is taken in. If the previous result is still stalled there,
// the handoff cycle repeats until it leaves.
module aes256_cbc_cipher (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  aes256_cbc_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output aes256_cbc_pkg::out_word_t out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [63:0]               cfg_data
);

  aes256_cbc_pkg::state_t state_r, state_nxt;

  logic [3:0]   cnt_r;
  logic [7:0]   rcon_r;
  logic [127:0] kp1_r, kp2_r;
  logic [127:0] rk_mem_r [aes256_cbc_pkg::NUM_RKEYS];
  logic [63:0]  key_r [4];
  logic [63:0]  iv_hi_r, iv_lo_r;
  logic         dir_r;
  logic         keys_ready_r;
  logic [127:0] cv_r, in_r, s_r;
  aes256_cbc_pkg::out_word_t out_r;
  logic         out_valid_r;

  logic         in_acc;
  logic         last_round;
  logic         out_free;
  logic [3:0]   rk_idx;
  logic [127:0] rk;
  logic [127:0] new_rk;
  logic [127:0] enc_sr, dec_sr, round_out;

  assign in_acc     = in_valid && !in_stall;
  assign last_round = (cnt_r == 4'(aes256_cbc_pkg::NUM_ROUNDS));
  assign out_free   = !out_valid_r || !out_stall;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aes256_cbc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = keys_ready_r ? aes256_cbc_pkg::ST_START : aes256_cbc_pkg::ST_EXPAND;
        end
      end
      aes256_cbc_pkg::ST_EXPAND: begin
        if (cnt_r == 4'(aes256_cbc_pkg::NUM_RKEYS - 1)) begin
          state_nxt = aes256_cbc_pkg::ST_START;
        end
      end
      aes256_cbc_pkg::ST_START: state_nxt = aes256_cbc_pkg::ST_ROUND;
      aes256_cbc_pkg::ST_ROUND: begin
        if (last_round) begin
          state_nxt = aes256_cbc_pkg::ST_FINISH;
        end
      end
      aes256_cbc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = aes256_cbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aes256_cbc_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = (state_r != aes256_cbc_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  // Round key read index: decryption walks the schedule backward.
  always_comb begin
    if (state_r == aes256_cbc_pkg::ST_START) begin
      rk_idx = dir_r ? 4'(aes256_cbc_pkg::NUM_ROUNDS) : 4'd0;
    end else begin
      rk_idx = dir_r ? 4'(aes256_cbc_pkg::NUM_ROUNDS) - cnt_r : cnt_r;
    end
  end
  assign rk = rk_mem_r[rk_idx];

  // Key schedule step: the first two round keys are the key itself.
  always_comb begin
    if (cnt_r == 4'd0) begin
      new_rk = {key_r[0], key_r[1]};
    end else if (cnt_r == 4'd1) begin
      new_rk = {key_r[2], key_r[3]};
    end else begin
      new_rk = aes256_cbc_pkg::next_round_key(kp2_r, kp1_r, rcon_r, !cnt_r[0]);
    end
  end

  // Shared round unit.
  always_comb begin
    enc_sr = aes256_cbc_pkg::shift_rows(aes256_cbc_pkg::sub_bytes(s_r, 1'b0), 1'b0);
    dec_sr = aes256_cbc_pkg::sub_bytes(aes256_cbc_pkg::shift_rows(s_r, 1'b1), 1'b1) ^ rk;
    if (dir_r) begin
      round_out = last_round ? (dec_sr ^ cv_r) : aes256_cbc_pkg::mix_columns(dec_sr, 1'b1);
    end else begin
      round_out = (last_round ? enc_sr : aes256_cbc_pkg::mix_columns(enc_sr, 1'b0)) ^ rk;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aes256_cbc_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      keys_ready_r <= 1'b0;
      cv_r         <= '0;
      key_r        <= '{default: '0};
      iv_hi_r      <= '0;
      iv_lo_r      <= '0;
      dir_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index) inside
          aes256_cbc_pkg::REG_KEY0, aes256_cbc_pkg::REG_KEY1,
          aes256_cbc_pkg::REG_KEY2, aes256_cbc_pkg::REG_KEY3: begin
            key_r[cfg_index[1:0]] <= cfg_data;
            keys_ready_r          <= 1'b0;
          end
          aes256_cbc_pkg::REG_IV_HIGH:   iv_hi_r <= cfg_data;
          aes256_cbc_pkg::REG_IV_LOW:    iv_lo_r <= cfg_data;
          aes256_cbc_pkg::REG_DIRECTION: dir_r   <= cfg_data[0];
          default: ;
        endcase
      end

      // A first block restarts the chain from the IV.
      if (in_acc && in_data.first_block) begin
        cv_r <= {iv_hi_r, iv_lo_r};
      end

      if (state_r == aes256_cbc_pkg::ST_EXPAND &&
          cnt_r == 4'(aes256_cbc_pkg::NUM_RKEYS - 1)) begin
        keys_ready_r <= 1'b1;
      end

      // Chain on the ciphertext: the result when encrypting, the input otherwise.
      if (state_r == aes256_cbc_pkg::ST_ROUND && last_round) begin
        cv_r <= dir_r ? in_r : round_out;
      end

      if (state_r == aes256_cbc_pkg::ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r   <= {in_data.block_high, in_data.block_low};
      cnt_r  <= '0;
      rcon_r <= 8'h01;
    end

    if (state_r == aes256_cbc_pkg::ST_EXPAND) begin
      rk_mem_r[cnt_r] <= new_rk;
      kp2_r           <= kp1_r;
      kp1_r           <= new_rk;
      if (cnt_r == 4'(aes256_cbc_pkg::NUM_RKEYS - 1)) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 4'd1;
      end
      if (cnt_r >= 4'd2 && !cnt_r[0]) begin
        rcon_r <= aes256_cbc_pkg::xtime(rcon_r);
      end
    end

    // Initial key addition; encryption folds in the chaining vector here.
    if (state_r == aes256_cbc_pkg::ST_START) begin
      s_r   <= dir_r ? (in_r ^ rk) : (in_r ^ cv_r ^ rk);
      cnt_r <= 4'd1;
    end

    if (state_r == aes256_cbc_pkg::ST_ROUND) begin
      s_r   <= round_out;
      cnt_r <= cnt_r + 4'd1;
    end

    if (state_r == aes256_cbc_pkg::ST_FINISH && out_free) begin
      out_r.result_high <= s_r[127:64];
      out_r.result_low  <= s_r[63:0];
    end
  end

endmodule

// ===== test/aes256_cbc_checker.sv =====
// ----------------------------------------------------------------------------
// AES-256 CBC checker
// Watches the configuration, input and result channels of the cipher. Keeps
// its own copy of the registers, round keys and chaining vector, works out
// the expected result block for every accepted input word and compares each
// accepted result word with the oldest expected block.
// ----------------------------------------------------------------------------
module aes256_cbc_checker
  import aes256_cbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          pending,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] FWD_COEF [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
  localparam logic [7:0] INV_COEF [4] = '{8'd14, 8'd11, 8'd13, 8'd9};

  // Register copies and cipher state as the block should hold them.
  logic [63:0]  key_reg [4];
  logic [63:0]  iv_hi, iv_lo;
  logic         decrypt;
  logic [127:0] chain;
  logic [127:0] rkey [15];
  logic         keys_stale;
  out_word_t    expected_q [$];

  // GF(2^8) multiply by shift and add.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [127:0] sub_state(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0]   b;
    for (int i = 0; i < 16; i++) begin
      b = s[127-8*i -: 8];
      o[127-8*i -: 8] = inv ? INV_SBOX[b] : SBOX[b];
    end
    return o;
  endfunction

  // Byte 4c+r is row r of column c.
  function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) o[127-8*(((c+r)%4)*4+r) -: 8] = s[127-8*(c*4+r) -: 8];
        else o[127-8*(c*4+r) -: 8] = s[127-8*(((c+r)%4)*4+r) -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] col_mix(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0]   v, coef;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = '0;
        for (int k = 0; k < 4; k++) begin
          coef = inv ? INV_COEF[(k-r+4)%4] : FWD_COEF[(k-r+4)%4];
          v ^= gf_mul(s[127-8*(4*c+k) -: 8], coef);
        end
        o[127-8*(4*c+r) -: 8] = v;
      end
    end
    return o;
  endfunction

  // Rebuild the 15 round keys from the key registers.
  task automatic expand_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = key_reg[i/2][63-32*(i%2) -: 32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]} ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (i % 8 == 4) begin
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    keys_stale = 1'b0;
  endtask

  // One CBC block in the current direction; updates the chaining vector.
  function automatic logic [127:0] cbc_block(input logic [127:0] blk);
    logic [127:0] s;
    if (!decrypt) begin
      s = (blk ^ chain) ^ rkey[0];
      for (int r = 1; r < NUM_ROUNDS; r++)
        s = col_mix(row_shift(sub_state(s, 1'b0), 1'b0), 1'b0) ^ rkey[r];
      s = row_shift(sub_state(s, 1'b0), 1'b0) ^ rkey[NUM_ROUNDS];
      chain = s;
    end else begin
      s = blk ^ rkey[NUM_ROUNDS];
      for (int r = NUM_ROUNDS - 1; r > 0; r--)
        s = col_mix(sub_state(row_shift(s, 1'b1), 1'b1) ^ rkey[r], 1'b1);
      s = sub_state(row_shift(s, 1'b1), 1'b1) ^ rkey[0] ^ chain;
      chain = blk;
    end
    return s;
  endfunction

  // Track configuration, predict on input words and compare result words.
  always @(posedge clk) begin
    out_word_t    want;
    logic [127:0] res;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      iv_hi = '0;
      iv_lo = '0;
      decrypt = 1'b0;
      chain = '0;
      keys_stale = 1'b1;
      expected_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key_reg[cfg_index[1:0]] = cfg_data;
            keys_stale = 1'b1;
          end
          REG_IV_HIGH: iv_hi = cfg_data;
          REG_IV_LOW: iv_lo = cfg_data;
          REG_DIRECTION: decrypt = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (keys_stale) expand_keys();
        if (in_data.first_block) chain = {iv_hi, iv_lo};
        res = cbc_block({in_data.block_high, in_data.block_low});
        want.result_high = res[127:64];
        want.result_low = res[63:0];
        expected_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word with no block outstanding: %h %h",
                 out_data.result_high, out_data.result_low);
          errs = 1;
        end else begin
          want = expected_q.pop_front();
          if (out_data.result_high !== want.result_high) begin
            $error("result_high expected %h actual %h", want.result_high,
                   out_data.result_high);
            errs = errs + 1;
          end
          if (out_data.result_low !== want.result_low) begin
            $error("result_low expected %h actual %h", want.result_low,
                   out_data.result_low);
            errs = errs + 1;
          end
        end
      end
      mismatches <= mismatches + errs;
    end
    pending <= expected_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// AES-256 CBC cipher testbench
// Drives directed and random blocks through the cipher under several key,
// IV and direction settings and under four mixes of sender idling and
// receiver stalls; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aes256_cbc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  // Register index that maps to no register.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          pending;
  int          mismatches;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          blocks_sent = 0;
  int          reconfigs = 0;

  aes256_cbc_cipher DUT (.*);

  aes256_cbc_checker chk (.*);

  always #5 clk = ~clk;

  // Receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one block word, with a random idle gap first; valid stays high after.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic first);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{block_high: hi, block_low: lo, first_block: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    blocks_sent++;
  endtask

  // Hold the input until every expected result word is back, then settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [63:0] pick64();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Random settings; keys change only now and then.
  task automatic random_setup();
    drain();
    if ($urandom_range(1)) begin
      write_reg(REG_KEY0, pick64());
      write_reg(REG_KEY1, pick64());
      write_reg(REG_KEY2, pick64());
      write_reg(REG_KEY3, pick64());
    end
    write_reg(REG_IV_HIGH, pick64());
    write_reg(REG_IV_LOW, pick64());
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, pick64());
    write_reg(REG_DIRECTION, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    reconfigs++;
  endtask

  initial begin
    logic [63:0] hi, lo;
    int          sel;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no first block after reset chains on a zero vector, zero key.
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    drain();
    // Standard test key and plaintext, then extremes and chaining.
    write_reg(REG_KEY0, 64'h0001020304050607);
    write_reg(REG_KEY1, 64'h08090a0b0c0d0e0f);
    write_reg(REG_KEY2, 64'h1011121314151617);
    write_reg(REG_KEY3, 64'h18191a1b1c1d1e1f);
    write_reg(REG_IV_HIGH, '0);
    write_reg(REG_IV_LOW, '0);
    write_reg(REG_DIRECTION, '0);
    cfg_valid <= 1'b0;
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    send_block('1, '1, 1'b0);
    send_block('0, '0, 1'b0);
    drain();
    // A new IV waits for the next first block.
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_IV_LOW, 64'h0123456789abcdef);
    cfg_valid <= 1'b0;
    send_block(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0);
    send_block(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b1);
    drain();
    // Direction turns mid-stream; wide data uses only the low bit.
    write_reg(REG_DIRECTION, 64'hffff_ffff_ffff_ffff);
    cfg_valid <= 1'b0;
    send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    send_block('1, '0, 1'b1);
    drain();
    write_reg(REG_DIRECTION, 64'hffff_ffff_ffff_fffe);
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_block('0, '1, 1'b0);
    drain();
    // Key change mid-stream forces a fresh schedule.
    write_reg(REG_KEY2, '1);
    write_reg(REG_DIRECTION, 64'd1);
    cfg_valid <= 1'b0;
    send_block(64'hdeadbeefcafef00d, 64'h0badc0de12345678, 1'b0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);

    // Random: four idle/stall mixes, settings changed between groups.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 81 : 31) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 81 : 31) : 0;
      for (int g = 0; g < 5; g++) begin
        random_setup();
        for (int n = 0; n < 25; n++) begin
          sel = $urandom_range(9);
          hi = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
          lo = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
          send_block(hi, lo, ($urandom_range(99) < 15));
        end
      end
    end

    drain();
    $display("Checked %0d blocks across %0d register setups,", blocks_sent, reconfigs);
    $display("encrypt and decrypt, under four idle and stall mixes.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
